// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
// Both sample on the rising edge of clk and are held off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every sampled edge.
`define LKV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression must never be true at a sampled edge.
`define LKV_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== hw/rtl/lkv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lkv_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Request codes
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  // Returned on a get miss and on every put
  localparam logic signed [VAL_W-1:0] MISS_VALUE = '1;

  typedef struct packed {
    logic                    req_type;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
  } rsp_t;

  // Lookup outcome from the tag array to the data store
  typedef struct packed {
    logic hit;
    logic wr;
  } lkv_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lru_key_value_cache.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                 Payload
// request   start / busy              req  (req_type, key, value)
// result    done strobe, no stall     rsp  (found, read_value)
// config    cfg_valid / cfg_ready     cfg_data (capacity)
//
// A request is taken every cycle; busy stays low.
// Each result passes through the input register and the result register around
// the parallel key compare and rank update.
// rst (synchronous) empties the cache and sets capacity to 16.
// Results cannot be stalled; done is high for one cycle per request.

module lru_key_value_cache import lkv_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output      logic             busy,
  input  wire req_t             req,
  output      logic             done,
  output      rsp_t             rsp,
  input  wire logic             cfg_valid,
  output      logic             cfg_ready,
  input  wire logic [CAP_W-1:0] cfg_data
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [CAP_W-1:0] capacity;
  logic             vld_q;
  req_t             req_q;
  lkv_ctl_t         ctl;
  logic [IDX_W-1:0] slot;
  logic [VAL_W-1:0] rdata;
  logic             found_q;
  logic             get_q;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      vld_q    <= 1'b0;
      done     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      vld_q <= start && !busy;
      done  <= vld_q;
    end
  end

  always_ff @(posedge clk) begin
    req_q   <= req;
    found_q <= ctl.hit;
    get_q   <= req_q.req_type == REQ_GET;
  end

  lkv_tags #(.ENTRIES(ENTRIES)) u_tags (
    .clk      (clk),
    .rst      (rst),
    .vld      (vld_q),
    .req      (req_q),
    .capacity (capacity),
    .ctl      (ctl),
    .slot     (slot)
  );

  lkv_data_ram #(.ENTRIES(ENTRIES)) u_data (
    .clk   (clk),
    .ctl   (ctl),
    .addr  (slot),
    .wdata (req_q.value),
    .rdata (rdata)
  );

  assign rsp.found      = found_q;
  assign rsp.read_value = (found_q && get_q) ? rdata : MISS_VALUE;

endmodule

`default_nettype wire

// ===== hw/rtl/lkv_tags.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lkv_tags import lkv_pkg::*; #(
  parameter int ENTRIES = 16,
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             vld,
  input  wire req_t             req,
  input  wire logic [CAP_W-1:0] capacity,
  output      lkv_ctl_t         ctl,
  output      logic [IDX_W-1:0] slot
);

  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  logic [KEY_W-1:0] keys [ENTRIES];
  logic [IDX_W-1:0] rank [ENTRIES];
  logic [OCC_W-1:0] occupancy;

  logic [ENTRIES-1:0] in_use;
  logic [ENTRIES-1:0] hit_vec;
  logic [ENTRIES-1:0] old_vec;
  logic [IDX_W-1:0]   hit_idx;
  logic [IDX_W-1:0]   victim_idx;
  logic [IDX_W-1:0]   hit_rank;
  logic [IDX_W-1:0]   oldest_rank;
  logic [IDX_W-1:0]   thr;
  logic [CMP_W-1:0]   eff_cap;
  logic               hit;
  logic               full;
  logic               is_put;
  logic               touch;
  logic               fill;

  always_comb begin
    oldest_rank = IDX_W'(occupancy - OCC_W'(1));
    hit_idx     = '0;
    victim_idx  = '0;
    hit_rank    = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      in_use[i]  = OCC_W'(i) < occupancy;
      hit_vec[i] = in_use[i] && (keys[i] == req.key);
      old_vec[i] = in_use[i] && (rank[i] == oldest_rank);
      // Keys in use are unique, so at most one lane hits
      if (hit_vec[i]) begin
        hit_idx  = hit_idx | IDX_W'(i);
        hit_rank = hit_rank | rank[i];
      end
      if (old_vec[i]) begin
        victim_idx = victim_idx | IDX_W'(i);
      end
    end

    if (capacity == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(capacity) > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = CMP_W'(capacity);
    end

    hit    = |hit_vec;
    full   = CMP_W'(occupancy) >= eff_cap;
    is_put = req.req_type == REQ_PUT;
    touch  = vld && (hit || is_put);
    fill   = vld && is_put && !hit && !full;

    // Target slot and the rank below which entries age by one
    if (hit) begin
      slot = hit_idx;
      thr  = hit_rank;
    end else if (full) begin
      slot = victim_idx;
      thr  = oldest_rank;
    end else begin
      slot = IDX_W'(occupancy);
      thr  = IDX_W'(occupancy);
    end

    ctl.hit = hit;
    ctl.wr  = vld && is_put;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      if (touch) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (IDX_W'(i) == slot) begin
            rank[i] <= '0;
          end else if (in_use[i] && (rank[i] < thr)) begin
            rank[i] <= rank[i] + IDX_W'(1);
          end
        end
      end
      if (fill) begin
        occupancy <= occupancy + OCC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vld && is_put && !hit) begin
      keys[slot] <= req.key;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lkv_data_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lkv_data_ram import lkv_pkg::*; #(
  parameter int ENTRIES = 16,
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  wire logic             clk,
  input  wire lkv_ctl_t         ctl,
  input  wire logic [IDX_W-1:0] addr,
  input  wire logic [VAL_W-1:0] wdata,
  output      logic [VAL_W-1:0] rdata
);

  logic [VAL_W-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[addr] <= wdata;
    end
  end

  // Read-first: a get never writes, so the old word is what it wants
  always_ff @(posedge clk) begin
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lkv_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module lkv_checker import lkv_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire req_t req,
  input wire logic done,
  input wire rsp_t rsp
);

  `LKV_ASSERT(a_done_after_beat, (start && !busy) |-> ##2 done, "result beat missing")
  `LKV_ASSERT_NEVER(a_no_stray_done, done && !$past(start && !busy, 2), "result without request")
  `LKV_ASSERT(a_miss_reads_ones, (done && !rsp.found) |-> (rsp.read_value == MISS_VALUE), "miss value")
  `LKV_ASSERT(a_put_then_get, (start && !busy && req.req_type == REQ_PUT) ##1 (start && !busy && req.req_type == REQ_GET && req.key == $past(req.key)) |=> ##1 (done && rsp.found && rsp.read_value == $past(req.value, 3)), "get after put lost the value")

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (.*);

`default_nettype wire
